@@ rtl/class_aware_box_nms_assert.svh @@
// Assertion macros shared by the class-aware NMS RTL.
// Included by modules that check their own control logic; needs nothing else.
`ifndef CLASS_AWARE_BOX_NMS_ASSERT_SVH
`define CLASS_AWARE_BOX_NMS_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define CABN_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define CABN_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/cabn_pkg.sv @@
// Shared constants and controller/datapath types for the class-aware NMS block.
// No dependencies.
package cabn_pkg;

   localparam int MAX_DETS_DEF   = 64;
   localparam int COORD_BITS_DEF = 16;
   localparam int SCORE_BITS_DEF = 16;
   localparam int CLASS_BITS_DEF = 8;

   localparam int SIZE_BITS = 15;
   localparam int KEEP_BITS = 6;
   localparam int THR_BITS  = 16;
   localparam int FRAC_BITS = 16;
   localparam logic [THR_BITS-1:0] THR_RESET = 16'h8000;

   typedef struct packed {
      logic load_en;
      logic scan_clr;
      logic scan_rd;
      logic supp_rd;
      logic take_pick;
      logic capture_pick;
      logic push_out;
      logic push_last;
      logic batch_clr;
   } cmd_type;

   typedef struct packed {
      logic found;
      logic busy;
   } status_type;

endpackage

@@ rtl/cabn_ifs.sv @@
// Valid/ready channel interfaces for the class-aware NMS block.
// Depends on cabn_pkg for field widths.
interface cabn_req_if #(
   parameter int COORD_BITS = cabn_pkg::COORD_BITS_DEF,
   parameter int SCORE_BITS = cabn_pkg::SCORE_BITS_DEF,
   parameter int CLASS_BITS = cabn_pkg::CLASS_BITS_DEF
);
   logic                               valid;
   logic                               ready;
   logic signed [COORD_BITS-1:0]       box_x;
   logic signed [COORD_BITS-1:0]       box_y;
   logic [cabn_pkg::SIZE_BITS-1:0]     box_w;
   logic [cabn_pkg::SIZE_BITS-1:0]     box_h;
   logic [CLASS_BITS-1:0]              det_class;
   logic [SCORE_BITS-1:0]              det_score;
   logic                               last_item;

   modport source (output valid, box_x, box_y, box_w, box_h, det_class, det_score,
                   last_item, input ready);
   modport sink (input valid, box_x, box_y, box_w, box_h, det_class, det_score,
                 last_item, output ready);
endinterface

interface cabn_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [cabn_pkg::KEEP_BITS-1:0] keep_index;
   logic                           last_result;
   logic                           overflow;

   modport source (output valid, keep_index, last_result, overflow, input ready);
   modport sink (input valid, keep_index, last_result, overflow, output ready);
endinterface

interface cabn_csr_if;
   logic                          valid;
   logic                          ready;
   logic [cabn_pkg::THR_BITS-1:0] data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

@@ rtl/cabn_ctrl.sv @@
// Sequencer for the class-aware NMS block: load, best-score scan, suppression pass,
// result hand-off. Depends on cabn_pkg and class_aware_box_nms_assert.svh.
`include "class_aware_box_nms_assert.svh"

module cabn_ctrl #(
   parameter int MAX_DETS = cabn_pkg::MAX_DETS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_last,
   output logic                          req_ready,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  cabn_pkg::status_type          status,
   input  logic [$clog2(MAX_DETS):0]     batch_len,
   output cabn_pkg::cmd_type             cmd,
   output logic [$clog2(MAX_DETS)-1:0]   scan_addr
);
   localparam int IW = $clog2(MAX_DETS);

   localparam logic [2:0] S_LOAD = 3'd0;
   localparam logic [2:0] S_SCAN = 3'd1;
   localparam logic [2:0] S_PICK = 3'd2;
   localparam logic [2:0] S_BEST = 3'd3;
   localparam logic [2:0] S_SUPP = 3'd4;

   logic [2:0]  state_ff, state_in;
   logic [IW:0] cnt_ff, cnt_in;
   logic        pend_ff, pend_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_LOAD);
   assign rsp_valid = rsp_valid_ff;
   assign scan_addr = cnt_ff[IW-1:0];

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      pend_in  = pend_ff;
      cmd      = '0;
      case (state_ff)
         S_LOAD: begin
            if (req_valid) begin
               cmd.load_en = 1'b1;
               if (req_last) begin
                  cnt_in       = '0;
                  cmd.scan_clr = 1'b1;
                  state_in     = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (cnt_ff < batch_len) begin
               cmd.scan_rd = 1'b1;
               cnt_in      = cnt_ff + 1'b1;
            end else if (!status.busy) begin
               state_in = S_PICK;
            end
         end
         S_PICK: begin
            if (status.found) begin
               // hand the previous pick downstream before it is replaced
               if (!pend_ff || out_free) begin
                  cmd.push_out  = pend_ff;
                  cmd.take_pick = 1'b1;
                  pend_in       = 1'b1;
                  state_in      = S_BEST;
               end
            end else if (out_free) begin
               cmd.push_out  = 1'b1;
               cmd.push_last = 1'b1;
               cmd.batch_clr = 1'b1;
               pend_in       = 1'b0;
               state_in      = S_LOAD;
            end
         end
         S_BEST: begin
            cmd.capture_pick = 1'b1;
            cnt_in           = '0;
            state_in         = S_SUPP;
         end
         S_SUPP: begin
            if (cnt_ff < batch_len) begin
               cmd.supp_rd = 1'b1;
               cnt_in      = cnt_ff + 1'b1;
            end else if (!status.busy) begin
               cnt_in       = '0;
               cmd.scan_clr = 1'b1;
               state_in     = S_SCAN;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.push_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `CABN_ASSERT_NOW(a_push_free, clock, reset, cmd.push_out, out_free, "push over held item")
   `CABN_ASSERT_NOW(a_pick_found, clock, reset, cmd.take_pick, status.found, "pick without find")
   `CABN_ASSERT_NEXT(a_last_idle, clock, reset, cmd.push_last,
      (state_ff == S_LOAD) && !pend_ff && rsp_valid_ff, "batch end left state")
endmodule

@@ rtl/cabn_dp.sv @@
// Datapath for the class-aware NMS block: detection memories, handled flags,
// best-score tracker, pipelined integer IoU test, result register. Depends on cabn_pkg.
module cabn_dp #(
   parameter int MAX_DETS   = cabn_pkg::MAX_DETS_DEF,
   parameter int COORD_BITS = cabn_pkg::COORD_BITS_DEF,
   parameter int SCORE_BITS = cabn_pkg::SCORE_BITS_DEF,
   parameter int CLASS_BITS = cabn_pkg::CLASS_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  cabn_pkg::cmd_type                  cmd,
   input  logic [$clog2(MAX_DETS)-1:0]        scan_addr,
   input  logic signed [COORD_BITS-1:0]       box_x,
   input  logic signed [COORD_BITS-1:0]       box_y,
   input  logic [cabn_pkg::SIZE_BITS-1:0]     box_w,
   input  logic [cabn_pkg::SIZE_BITS-1:0]     box_h,
   input  logic [CLASS_BITS-1:0]              det_class,
   input  logic [SCORE_BITS-1:0]              det_score,
   input  logic                               csr_wr,
   input  logic [cabn_pkg::THR_BITS-1:0]      csr_data,
   output cabn_pkg::status_type               status,
   output logic [$clog2(MAX_DETS):0]          batch_len,
   output logic [cabn_pkg::KEEP_BITS-1:0]     keep_index,
   output logic                               last_result,
   output logic                               overflow
);
   localparam int IW = $clog2(MAX_DETS);
   localparam int SB = cabn_pkg::SIZE_BITS;
   localparam int EW = ((COORD_BITS > SB) ? COORD_BITS : SB + 1) + 1;
   localparam int AW = 2 * SB;
   localparam int UW = AW + 1;
   localparam int PW = cabn_pkg::THR_BITS + UW;

   // detection memories, one entry per loaded item
   logic signed [COORD_BITS-1:0] mem_x [MAX_DETS];
   logic signed [COORD_BITS-1:0] mem_y [MAX_DETS];
   logic [SB-1:0]                mem_w [MAX_DETS];
   logic [SB-1:0]                mem_h [MAX_DETS];
   logic [CLASS_BITS-1:0]        mem_c [MAX_DETS];
   logic [SCORE_BITS-1:0]        mem_s [MAX_DETS];

   logic signed [COORD_BITS-1:0] rd_x_ff, rd_y_ff, pk_x_ff, pk_y_ff;
   logic [SB-1:0]                rd_w_ff, rd_h_ff, pk_w_ff, pk_h_ff;
   logic [CLASS_BITS-1:0]        rd_c_ff, pk_c_ff;
   logic [SCORE_BITS-1:0]        rd_s_ff, best_s_ff;
   logic [AW-1:0]                pk_area_ff;

   logic [IW:0]                  cnt_ff;
   logic                         ovf_ff;
   logic [MAX_DETS-1:0]          handled_ff;
   logic [cabn_pkg::THR_BITS-1:0] thr_ff;

   logic [IW-1:0] rd_addr, best_ff, pend_ff;
   logic          rd_en, found_ff;
   logic          sv_ff;
   logic [IW-1:0] sidx_ff;

   // suppression pipeline
   logic          v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic [IW-1:0] i1_ff, i2_ff, i3_ff, i4_ff, i5_ff;
   logic          h2_ff, h3_ff, h4_ff, h5_ff;
   logic [SB-1:0] iw2_ff, ih2_ff, w2_ff, h2w_ff;
   logic [AW-1:0] inter3_ff, area3_ff, inter4_ff;
   logic [UW-1:0] uni4_ff;
   logic [PW-1:0] prod5_ff, shl5_ff;

   logic signed [EW-1:0] rx, ry, px, py, rx2, ry2, px2, py2, x1, y1, x2, y2, iw, ih;
   logic                 hit1;

   assign rd_en   = cmd.scan_rd || cmd.supp_rd || cmd.take_pick;
   assign rd_addr = cmd.take_pick ? best_ff : scan_addr;

   always_ff @(posedge clock) begin
      if (cmd.load_en && (cnt_ff < (IW+1)'(MAX_DETS))) begin
         mem_x[cnt_ff[IW-1:0]] <= box_x;
         mem_y[cnt_ff[IW-1:0]] <= box_y;
         mem_w[cnt_ff[IW-1:0]] <= box_w;
         mem_h[cnt_ff[IW-1:0]] <= box_h;
         mem_c[cnt_ff[IW-1:0]] <= det_class;
         mem_s[cnt_ff[IW-1:0]] <= det_score;
      end
      if (rd_en) begin
         rd_x_ff <= mem_x[rd_addr];
         rd_y_ff <= mem_y[rd_addr];
         rd_w_ff <= mem_w[rd_addr];
         rd_h_ff <= mem_h[rd_addr];
         rd_c_ff <= mem_c[rd_addr];
         rd_s_ff <= mem_s[rd_addr];
      end
   end

   // geometry of the candidate against the current pick
   always_comb begin
      rx  = EW'(rd_x_ff);
      ry  = EW'(rd_y_ff);
      px  = EW'(pk_x_ff);
      py  = EW'(pk_y_ff);
      rx2 = rx + $signed({{(EW-SB){1'b0}}, rd_w_ff});
      ry2 = ry + $signed({{(EW-SB){1'b0}}, rd_h_ff});
      px2 = px + $signed({{(EW-SB){1'b0}}, pk_w_ff});
      py2 = py + $signed({{(EW-SB){1'b0}}, pk_h_ff});
      x1  = (rx > px) ? rx : px;
      y1  = (ry > py) ? ry : py;
      x2  = (rx2 < px2) ? rx2 : px2;
      y2  = (ry2 < py2) ? ry2 : py2;
      iw  = x2 - x1;
      ih  = y2 - y1;
      hit1 = (iw > 0) && (ih > 0) && (rd_c_ff == pk_c_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.capture_pick) begin
         pk_x_ff <= rd_x_ff;
         pk_y_ff <= rd_y_ff;
         pk_w_ff <= rd_w_ff;
         pk_h_ff <= rd_h_ff;
         pk_c_ff <= rd_c_ff;
      end
      pk_area_ff <= pk_w_ff * pk_h_ff;

      i1_ff  <= rd_addr;
      i2_ff  <= i1_ff;
      h2_ff  <= hit1;
      iw2_ff <= iw[SB-1:0];
      ih2_ff <= ih[SB-1:0];
      w2_ff  <= rd_w_ff;
      h2w_ff <= rd_h_ff;

      i3_ff     <= i2_ff;
      h3_ff     <= h2_ff;
      inter3_ff <= iw2_ff * ih2_ff;
      area3_ff  <= w2_ff * h2w_ff;

      i4_ff     <= i3_ff;
      h4_ff     <= h3_ff;
      inter4_ff <= inter3_ff;
      uni4_ff   <= UW'(pk_area_ff) + UW'(area3_ff) - UW'(inter3_ff);

      i5_ff    <= i4_ff;
      h5_ff    <= h4_ff;
      prod5_ff <= thr_ff * uni4_ff;
      shl5_ff  <= PW'({inter4_ff, {cabn_pkg::FRAC_BITS{1'b0}}});

      sidx_ff <= rd_addr;
      if (sv_ff && !handled_ff[sidx_ff] && (!found_ff || (rd_s_ff > best_s_ff))) begin
         best_ff   <= sidx_ff;
         best_s_ff <= rd_s_ff;
      end
      if (cmd.take_pick) begin
         pend_ff <= best_ff;
      end
      if (cmd.push_out) begin
         keep_index  <= cabn_pkg::KEEP_BITS'(pend_ff);
         last_result <= cmd.push_last;
         overflow    <= ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff      <= 1'b0;
         v2_ff      <= 1'b0;
         v3_ff      <= 1'b0;
         v4_ff      <= 1'b0;
         v5_ff      <= 1'b0;
         sv_ff      <= 1'b0;
         found_ff   <= 1'b0;
         cnt_ff     <= '0;
         ovf_ff     <= 1'b0;
         handled_ff <= '0;
         thr_ff     <= cabn_pkg::THR_RESET;
      end else begin
         v1_ff <= cmd.supp_rd;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         sv_ff <= cmd.scan_rd;
         if (csr_wr) begin
            thr_ff <= csr_data;
         end
         if (cmd.scan_clr) begin
            found_ff <= 1'b0;
         end else if (sv_ff && !handled_ff[sidx_ff]) begin
            found_ff <= 1'b1;
         end
         if (cmd.load_en) begin
            if (cnt_ff < (IW+1)'(MAX_DETS)) begin
               cnt_ff <= cnt_ff + 1'b1;
            end else begin
               ovf_ff <= 1'b1;
            end
         end
         if (cmd.batch_clr) begin
            cnt_ff     <= '0;
            ovf_ff     <= 1'b0;
            handled_ff <= '0;
         end
         if (cmd.take_pick) begin
            handled_ff[best_ff] <= 1'b1;
         end
         // suppress: same class, overlapping, and inter * 65536 > threshold * union
         if (v5_ff && h5_ff && (shl5_ff > prod5_ff)) begin
            handled_ff[i5_ff] <= 1'b1;
         end
      end
   end

   assign status.found = found_ff;
   assign status.busy  = sv_ff || v1_ff || v2_ff || v3_ff || v4_ff || v5_ff;
   assign batch_len    = cnt_ff;
endmodule

@@ rtl/class_aware_box_nms.sv @@
// Class-aware greedy box NMS. Detections are loaded one item per cycle while req is
// ready; the item marked last closes the batch of N stored detections (up to MAX_DETS;
// extra items are dropped and flag overflow on every result of the batch). Each kept
// detection then costs one memory read per stored detection to find the highest
// unhandled score, then one read per detection streamed through a five-stage integer
// IoU pipeline. Loading takes no items while a batch is processed.
// Top level: ties the channels to cabn_ctrl and cabn_dp. Depends on cabn_pkg, cabn_ifs.
module class_aware_box_nms #(
   parameter int MAX_DETS   = cabn_pkg::MAX_DETS_DEF,
   parameter int COORD_BITS = cabn_pkg::COORD_BITS_DEF,
   parameter int SCORE_BITS = cabn_pkg::SCORE_BITS_DEF,
   parameter int CLASS_BITS = cabn_pkg::CLASS_BITS_DEF
) (
   input logic         clock,
   input logic         reset,
   cabn_req_if.sink    req_chan,
   cabn_rsp_if.source  rsp_chan,
   cabn_csr_if.sink    csr_chan
);
   cabn_pkg::cmd_type              cmd;
   cabn_pkg::status_type           status;
   logic [$clog2(MAX_DETS)-1:0]    scan_addr;
   logic [$clog2(MAX_DETS):0]      batch_len;

   assign csr_chan.ready = 1'b1;

   cabn_ctrl #(
      .MAX_DETS (MAX_DETS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_last  (req_chan.last_item),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .batch_len (batch_len),
      .cmd       (cmd),
      .scan_addr (scan_addr)
   );

   cabn_dp #(
      .MAX_DETS   (MAX_DETS),
      .COORD_BITS (COORD_BITS),
      .SCORE_BITS (SCORE_BITS),
      .CLASS_BITS (CLASS_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .scan_addr   (scan_addr),
      .box_x       (req_chan.box_x),
      .box_y       (req_chan.box_y),
      .box_w       (req_chan.box_w),
      .box_h       (req_chan.box_h),
      .det_class   (req_chan.det_class),
      .det_score   (req_chan.det_score),
      .csr_wr      (csr_chan.valid),
      .csr_data    (csr_chan.data),
      .status      (status),
      .batch_len   (batch_len),
      .keep_index  (rsp_chan.keep_index),
      .last_result (rsp_chan.last_result),
      .overflow    (rsp_chan.overflow)
   );
endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the class-aware greedy box NMS block.
// Drives detection batches and threshold writes through the block's interfaces,
// predicts kept indices in order, and checks them. Depends on cabn_pkg, cabn_ifs.
`timescale 1ns / 100ps

module tb_top;

   localparam int NDET = 64;
   localparam longint CYCLE_LIMIT = 3000000;

   typedef struct packed {
      logic [5:0] keep_index;
      logic       last_result;
      logic       overflow;
   } keep_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   err_count = 0;
   longint cycle_count = 0;

   cabn_req_if req_chan ();
   cabn_rsp_if rsp_chan ();
   cabn_csr_if csr_chan ();

   class_aware_box_nms u_dut (
      .clock(clock), .reset(reset),
      .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source), .csr_chan(csr_chan.sink)
   );

   // predictor state
   logic signed [15:0] st_x [NDET];
   logic signed [15:0] st_y [NDET];
   logic [14:0] st_w [NDET];
   logic [14:0] st_h [NDET];
   logic [7:0]  st_cls [NDET];
   logic [15:0] st_score [NDET];
   int          n_loaded = 0;
   bit          ovf_seen = 1'b0;
   logic [15:0] thr = cabn_pkg::THR_RESET;
   keep_type    keep_queue [$];

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic bit over_thr(int a, int b);
      longint ax, ay, aw, ah, bx, by, bw, bh;
      longint x1, y1, x2, y2, iw, ih, inter, uni;
      ax = longint'(st_x[a]);
      ay = longint'(st_y[a]);
      aw = longint'(st_w[a]);
      ah = longint'(st_h[a]);
      bx = longint'(st_x[b]);
      by = longint'(st_y[b]);
      bw = longint'(st_w[b]);
      bh = longint'(st_h[b]);
      x1 = (ax > bx) ? ax : bx;
      y1 = (ay > by) ? ay : by;
      x2 = ((ax + aw) < (bx + bw)) ? ax + aw : bx + bw;
      y2 = ((ay + ah) < (by + bh)) ? ay + ah : by + bh;
      iw = x2 - x1;
      ih = y2 - y1;
      if (iw <= 0 || ih <= 0) return 1'b0;
      inter = iw * ih;
      uni = aw * ah + bw * bh - inter;
      return (inter * 65536) > (longint'(thr) * uni);
   endfunction

   task automatic predict_keeps(input logic signed [15:0] x, y, input logic [14:0] w, h,
                                input logic [7:0] c, input logic [15:0] s, input bit last);
      bit done [NDET];
      int best;
      keep_type k;
      if (n_loaded < NDET) begin
         st_x[n_loaded] = x; st_y[n_loaded] = y; st_w[n_loaded] = w; st_h[n_loaded] = h;
         st_cls[n_loaded] = c; st_score[n_loaded] = s;
         n_loaded++;
      end else begin
         ovf_seen = 1'b1;
      end
      if (!last) return;
      foreach (done[i]) done[i] = 1'b0;
      forever begin
         best = -1;
         for (int i = 0; i < n_loaded; i++)
            if (!done[i] && (best < 0 || st_score[i] > st_score[best])) best = i;
         if (best < 0) break;
         done[best] = 1'b1;
         k.keep_index = best[5:0];
         k.last_result = 1'b0;
         k.overflow = ovf_seen;
         keep_queue.push_back(k);
         for (int i = 0; i < n_loaded; i++)
            if (!done[i] && st_cls[i] == st_cls[best] && over_thr(best, i)) done[i] = 1'b1;
      end
      k = keep_queue[$];
      k.last_result = 1'b1;
      keep_queue[$] = k;
      n_loaded = 0;
      ovf_seen = 1'b0;
   endtask

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      err_count++;
   endtask

   // result checker with random stall; handshake sampled at the falling edge
   initial begin
      int stall;
      keep_type want;
      keep_type got;
      rsp_chan.ready = 1'b0;
      @(posedge clock);
      forever begin
         stall = gap_len();
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(negedge clock);
         while (!rsp_chan.valid) @(negedge clock);
         got = {rsp_chan.keep_index, rsp_chan.last_result, rsp_chan.overflow};
         @(posedge clock);
         if (keep_queue.size() == 0) begin
            report_mismatch("unexpected item", int'(got.keep_index), -1);
         end else begin
            want = keep_queue.pop_front();
            if (got.keep_index !== want.keep_index)
               report_mismatch("keep_index", int'(got.keep_index), int'(want.keep_index));
            if (got.last_result !== want.last_result)
               report_mismatch("last_result", int'(got.last_result),
                               int'(want.last_result));
            if (got.overflow !== want.overflow)
               report_mismatch("overflow", int'(got.overflow), int'(want.overflow));
         end
      end
   end

   task automatic send_det(input logic signed [15:0] x, y, input logic [14:0] w, h,
                           input logic [7:0] c, input logic [15:0] s, input bit last);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_chan.valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.box_x <= x; req_chan.box_y <= y; req_chan.box_w <= w; req_chan.box_h <= h;
      req_chan.det_class <= c; req_chan.det_score <= s; req_chan.last_item <= last;
      @(negedge clock);
      while (!req_chan.ready) @(negedge clock);
      @(posedge clock);
      predict_keeps(x, y, w, h, c, s, last);
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      while (keep_queue.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [15:0] value);
      drain();
      csr_chan.valid <= 1'b1;
      csr_chan.data <= value;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      csr_chan.valid <= 1'b0;
      thr = value;
   endtask

   task automatic send_random_det(input bit last, input bit clustered);
      logic signed [15:0] x, y;
      logic [14:0] w, h;
      if (clustered) begin
         x = 16'($urandom_range(0, 60)); y = 16'($urandom_range(0, 60));
         w = 15'($urandom_range(0, 50)); h = 15'($urandom_range(0, 50));
      end else begin
         x = 16'($urandom); y = 16'($urandom); w = 15'($urandom); h = 15'($urandom);
      end
      send_det(x, y, w, h, clustered ? 8'($urandom_range(0, 2)) : 8'($urandom),
               ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 3)) : 16'($urandom),
               last);
   endtask

   task automatic test_directed();
      // single detection batch
      send_det(16'sh8000, 16'sh8000, 15'h7fff, 15'h7fff, 8'hff, 16'hffff, 1'b1);
      // equal scores, identical boxes: tie to lowest index, second suppressed
      send_det(16'sd0, 16'sd0, 15'd10, 15'd10, 8'd1, 16'd100, 1'b0);
      send_det(16'sd0, 16'sd0, 15'd10, 15'd10, 8'd1, 16'd100, 1'b0);
      send_det(16'sd0, 16'sd0, 15'd10, 15'd10, 8'd2, 16'd100, 1'b0);
      send_det(16'sd5, 16'sd0, 15'd10, 15'd10, 8'd1, 16'd200, 1'b0);
      send_det(16'sd0, 16'sd0, 15'd0, 15'd0, 8'd1, 16'd0, 1'b0);
      send_det(16'sh7fff, 16'sh7fff, 15'h7fff, 15'h7fff, 8'd0, 16'hffff, 1'b1);
      // no overlap, zero-area
      send_det(16'sd0, 16'sd0, 15'd0, 15'd5, 8'd3, 16'd7, 1'b0);
      send_det(16'sd0, 16'sd0, 15'd0, 15'd5, 8'd3, 16'd7, 1'b1);
   endtask

   task automatic test_overflow();
      for (int i = 0; i < NDET + 3; i++) send_random_det(i == NDET + 2, 1'b1);
      // dropped item ends the batch
      for (int i = 0; i < NDET + 1; i++) send_random_det(i == NDET, 1'b0);
   endtask

   task automatic test_random(input int items);
      int left, n;
      left = items;
      while (left > 0) begin
         n = $urandom_range(1, 12);
         for (int i = 0; i < n; i++) send_random_det(i == n - 1, $urandom_range(0, 4) != 0);
         left -= n;
      end
   endtask

   initial begin
      req_chan.valid = 1'b0;
      req_chan.box_x = '0; req_chan.box_y = '0; req_chan.box_w = '0; req_chan.box_h = '0;
      req_chan.det_class = '0; req_chan.det_score = '0; req_chan.last_item = 1'b0;
      csr_chan.valid = 1'b0;
      csr_chan.data = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      write_threshold(16'h0000);
      test_directed();
      write_threshold(16'hffff);
      test_directed();
      write_threshold(16'h4000);
      test_overflow();
      test_random(90);
      write_threshold(16'($urandom));
      test_random(90);
      write_threshold(cabn_pkg::THR_RESET);
      test_random(90);
      drain();
      if (err_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
